// ===== rtl/gib_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gib_pkg
// Shared constants, widths and the arctangent table for the bearing pipeline.
// ----------------------------------------------------------------------------
package gib_pkg;

  // Number of CORDIC micro-rotations (12 to 32).
  localparam int CORDIC_STEPS = 20;

  // Coordinate to binary angle: one full turn is 3600000000 coordinate units.
  localparam logic [31:0] TURN_UNITS = 32'd3600000000;
  // floor(2^63 / TURN_UNITS): the reciprocal of one turn, scaled by 2^63.
  localparam logic [31:0] DIV_RECIP = 32'd2562047788;

  // CORDIC gain compensation in Q30.
  localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

  localparam logic [8:0] FULL_TURN_DEG = 9'd360;
  localparam logic [31:0] HALF_TURN_ANG = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN_ANG = 32'h4000_0000;

  // Internal datapath widths of the rotation and vectoring engines.
  localparam int SC_W = 34;
  localparam int AT_W = 36;

  // Pipeline latencies in clock cycles.
  localparam int DIV_LAT = 5;
  localparam int SC_LAT = CORDIC_STEPS + 2;
  localparam int MUL_LAT = 3;
  localparam int AT_LAT = CORDIC_STEPS + 4;
  localparam int TOTAL_LAT = DIV_LAT + 1 + SC_LAT + MUL_LAT + AT_LAT;

  // atan(2^-i) as a binary angle, 2^32 per turn.
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gib_angle_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gib_angle_div
// Converts a coordinate in 1e-7 degree to a 32-bit binary angle by reciprocal
// multiplication with a single correction step, five pipeline stages.
// ----------------------------------------------------------------------------
module gib_angle_div import gib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] coord,
  output logic               out_valid,
  output logic [31:0]        angle
);

  // Stage 0: magnitude and sign of the coordinate.
  logic        vld0;
  logic [31:0] mag0;
  logic        neg0;
  // Stage 1: product with the scaled reciprocal of one turn.
  logic        vld1;
  logic [62:0] prod1;
  logic [31:0] mag1;
  logic        neg1;
  // Stage 2: quotient estimate, at most one too low, and its back product.
  logic        vld2;
  logic [31:0] qe2;
  logic [63:0] back2;
  logic [31:0] mag2;
  logic        neg2;
  // Stage 3: corrected quotient.
  logic        vld3;
  logic [31:0] q3;
  logic        neg3;

  logic [31:0] qe1;
  logic [63:0] rem2;
  logic        ge2;

  assign qe1 = prod1[62:31];
  assign rem2 = {mag2, 32'd0} - back2;
  assign ge2 = (rem2 >= {32'd0, TURN_UNITS});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld0 <= in_valid;
      vld1 <= vld0;
      vld2 <= vld1;
      vld3 <= vld2;
      out_valid <= vld3;
    end
  end

  always_ff @(posedge clk) begin
    mag0  <= coord[31] ? (32'd0 - coord) : coord;
    neg0  <= coord[31];
    prod1 <= 63'({32'd0, mag0} * {32'd0, DIV_RECIP});
    mag1  <= mag0;
    neg1  <= neg0;
    qe2   <= qe1;
    back2 <= {32'd0, qe1} * {32'd0, TURN_UNITS};
    mag2  <= mag1;
    neg2  <= neg1;
    q3    <= qe2 + {31'd0, ge2};
    neg3  <= neg2;
    angle <= neg3 ? (32'd0 - q3) : q3;
  end

endmodule

// ===== rtl/gib_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gib_sincos
// Pipelined CORDIC rotation giving cosine and sine in Q30 of a binary angle.
// ----------------------------------------------------------------------------
module gib_sincos import gib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [31:0]        angle,
  output logic               out_valid,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  logic signed [SC_W-1:0] xs [0:CORDIC_STEPS];
  logic signed [SC_W-1:0] ys [0:CORDIC_STEPS];
  logic signed [SC_W-1:0] zs [0:CORDIC_STEPS];
  logic                   flip [0:CORDIC_STEPS];
  logic                   vld [0:CORDIC_STEPS];

  logic [31:0] a_rot;
  logic [31:0] a_adj;
  logic        flip_in;

  // Angles outside [-90, 90) degrees are turned by a half turn first.
  assign a_rot = angle + QUARTER_TURN_ANG;
  assign flip_in = a_rot[31];
  assign a_adj = flip_in ? (angle ^ HALF_TURN_ANG) : angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]   <= SC_W'(CORDIC_GAIN);
    ys[0]   <= '0;
    zs[0]   <= {{(SC_W-32){a_adj[31]}}, a_adj};
    flip[0] <= flip_in;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [SC_W-1:0] dx;
    logic signed [SC_W-1:0] dy;
    logic signed [SC_W-1:0] da;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    assign da = {{(SC_W-32){1'b0}}, atan_entry(5'(i))};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!zs[i][SC_W-1]) begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        zs[i+1] <= zs[i] - da;
      end else begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        zs[i+1] <= zs[i] + da;
      end
      flip[i+1] <= flip[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (flip[CORDIC_STEPS]) begin
      cos_q30 <= 32'(-xs[CORDIC_STEPS]);
      sin_q30 <= 32'(-ys[CORDIC_STEPS]);
    end else begin
      cos_q30 <= xs[CORDIC_STEPS][31:0];
      sin_q30 <= ys[CORDIC_STEPS][31:0];
    end
  end

endmodule

// ===== rtl/gib_atan2.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gib_atan2
// Pipelined CORDIC vectoring and conversion of the angle to whole degrees.
// ----------------------------------------------------------------------------
module gib_atan2 import gib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [32:0] east,
  input  logic signed [32:0] north,
  output logic               out_valid,
  output logic [8:0]         bearing
);

  logic signed [AT_W-1:0] re [0:CORDIC_STEPS];
  logic signed [AT_W-1:0] im [0:CORDIC_STEPS];
  logic [31:0]            zs [0:CORDIC_STEPS];
  logic                   zero [0:CORDIC_STEPS];
  logic                   vld [0:CORDIC_STEPS];

  logic signed [AT_W-1:0] east_x;
  logic signed [AT_W-1:0] north_x;

  assign east_x = AT_W'(east);
  assign north_x = AT_W'(north);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  // A vector in the southern half plane is turned by a half turn first.
  always_ff @(posedge clk) begin
    if (north[32]) begin
      re[0] <= -north_x;
      im[0] <= -east_x;
      zs[0] <= HALF_TURN_ANG;
    end else begin
      re[0] <= north_x;
      im[0] <= east_x;
      zs[0] <= '0;
    end
    zero[0] <= (east == '0) && (north == '0);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    logic signed [AT_W-1:0] dre;
    logic signed [AT_W-1:0] dim;
    logic [31:0]            da;
    assign dre = im[i] >>> i;
    assign dim = re[i] >>> i;
    assign da = atan_entry(5'(i));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!im[i][AT_W-1] && (im[i] != '0)) begin
        re[i+1] <= re[i] + dre;
        im[i+1] <= im[i] - dim;
        zs[i+1] <= zs[i] + da;
      end else begin
        re[i+1] <= re[i] - dre;
        im[i+1] <= im[i] + dim;
        zs[i+1] <= zs[i] - da;
      end
      zero[i+1] <= zero[i];
    end
  end

  // Magnitude of the signed angle.
  logic [31:0] mag;
  logic        mag_neg;
  logic        mag_zero;
  logic        mag_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_vld <= 1'b0;
    end else begin
      mag_vld <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    mag      <= zs[CORDIC_STEPS][31] ? (32'd0 - zs[CORDIC_STEPS]) : zs[CORDIC_STEPS];
    mag_neg  <= zs[CORDIC_STEPS][31];
    mag_zero <= zero[CORDIC_STEPS];
  end

  // Scale to degrees: truncated (mag * 360) / 2^32.
  logic [40:0] prod;
  logic [8:0]  deg;
  logic        deg_neg;
  logic        deg_zero;
  logic        deg_vld;

  assign prod = 41'(mag) * 41'(FULL_TURN_DEG);

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_vld <= 1'b0;
    end else begin
      deg_vld <= mag_vld;
    end
  end

  always_ff @(posedge clk) begin
    deg      <= prod[40:32];
    deg_neg  <= mag_neg;
    deg_zero <= mag_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= deg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (deg_zero) begin
      bearing <= '0;
    end else if (deg_neg && (deg != '0)) begin
      bearing <= FULL_TURN_DEG - deg;
    end else begin
      bearing <= deg;
    end
  end

endmodule

// ===== rtl/gps_initial_bearing_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gps_initial_bearing_core
// Great-circle initial bearing from a start to an end position, pipelined.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake         Payload
// input     in         start / busy      start_lat, start_lon, end_lat, end_lon
// result    out        done (strobe)     bearing_deg
//
// The block takes one item in every clock cycle; busy is always low because
// every stage moves forward on every clock. Each result passes in order through
// the five-stage coordinate converter, the rotation CORDICs, the multiply stages
// and the vectoring CORDIC pipeline.
// Reset clears only the valid bits of the stages; no clearing pass is needed.
// The receiver cannot stall, so results leave as a one-cycle done strobe.
//
// Datapath: four coordinates are turned into binary angles, the longitude
// difference is formed, three rotation CORDICs give the sines and cosines,
// three multiply stages form the east and north components, and a vectoring
// CORDIC with a degree scaler produces the bearing.
//
module gps_initial_bearing_core import gib_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] start_lat,
  input  logic signed [31:0] start_lon,
  input  logic signed [30:0] end_lat,
  input  logic signed [31:0] end_lon,
  output logic               done,
  output logic [8:0]         bearing_deg
);

  // The pipeline never holds off an item.
  assign busy = 1'b0;

  logic take;
  assign take = start && !busy;

  // Coordinate to binary angle conversion, one divider per coordinate.
  logic        lat1_vld;
  logic        lon1_vld;
  logic        lat2_vld;
  logic        lon2_vld;
  logic [31:0] lat1_ang;
  logic [31:0] lon1_ang;
  logic [31:0] lat2_ang;
  logic [31:0] lon2_ang;

  gib_angle_div u_div_lat1 (
    .clk(clk), .rst(rst), .in_valid(take), .coord({start_lat[30], start_lat}),
    .out_valid(lat1_vld), .angle(lat1_ang)
  );
  gib_angle_div u_div_lon1 (
    .clk(clk), .rst(rst), .in_valid(take), .coord(start_lon),
    .out_valid(lon1_vld), .angle(lon1_ang)
  );
  gib_angle_div u_div_lat2 (
    .clk(clk), .rst(rst), .in_valid(take), .coord({end_lat[30], end_lat}),
    .out_valid(lat2_vld), .angle(lat2_ang)
  );
  gib_angle_div u_div_lon2 (
    .clk(clk), .rst(rst), .in_valid(take), .coord(end_lon),
    .out_valid(lon2_vld), .angle(lon2_ang)
  );

  // Longitude difference, wrapping modulo a full turn.
  logic        ang_vld;
  logic [31:0] ang_lat1;
  logic [31:0] ang_lat2;
  logic [31:0] ang_dlon;

  always_ff @(posedge clk) begin
    if (rst) begin
      ang_vld <= 1'b0;
    end else begin
      ang_vld <= lat1_vld;
    end
  end

  always_ff @(posedge clk) begin
    ang_lat1 <= lat1_ang;
    ang_lat2 <= lat2_ang;
    ang_dlon <= lon2_ang - lon1_ang;
  end

  // Sines and cosines of both latitudes and the longitude difference.
  logic               sc_vld;
  logic               sc2_vld;
  logic               scd_vld;
  logic signed [31:0] c1;
  logic signed [31:0] s1;
  logic signed [31:0] c2;
  logic signed [31:0] s2;
  logic signed [31:0] cd;
  logic signed [31:0] sd;

  gib_sincos u_sc_lat1 (
    .clk(clk), .rst(rst), .in_valid(ang_vld), .angle(ang_lat1),
    .out_valid(sc_vld), .cos_q30(c1), .sin_q30(s1)
  );
  gib_sincos u_sc_lat2 (
    .clk(clk), .rst(rst), .in_valid(ang_vld), .angle(ang_lat2),
    .out_valid(sc2_vld), .cos_q30(c2), .sin_q30(s2)
  );
  gib_sincos u_sc_dlon (
    .clk(clk), .rst(rst), .in_valid(ang_vld), .angle(ang_dlon),
    .out_valid(scd_vld), .cos_q30(cd), .sin_q30(sd)
  );

  // First multiply stage: cos2*sin(dlon), sin1*cos2 and cos1*sin2.
  logic               p1_vld;
  logic signed [63:0] p_east;
  logic signed [63:0] p_t;
  logic signed [63:0] p_a;
  logic signed [31:0] cd_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else begin
      p1_vld <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    p_east <= c2 * sd;
    p_t    <= s1 * c2;
    p_a    <= c1 * s2;
    cd_p1  <= cd;
  end

  // Second multiply stage: the Q30 product sin1*cos2 times cos(dlon).
  logic               p2_vld;
  logic signed [31:0] t_q30;
  logic signed [31:0] east_p2;
  logic signed [31:0] a_p2;
  logic signed [63:0] p_b;

  assign t_q30 = p_t[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_vld <= 1'b0;
    end else begin
      p2_vld <= p1_vld;
    end
  end

  always_ff @(posedge clk) begin
    east_p2 <= p_east[61:30];
    a_p2    <= p_a[61:30];
    p_b     <= t_q30 * cd_p1;
  end

  // Third stage: north component as the difference of the two terms.
  logic               p3_vld;
  logic signed [32:0] east_p3;
  logic signed [32:0] north_p3;
  logic signed [31:0] b_q30;

  assign b_q30 = p_b[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_vld <= 1'b0;
    end else begin
      p3_vld <= p2_vld;
    end
  end

  always_ff @(posedge clk) begin
    east_p3  <= {east_p2[31], east_p2};
    north_p3 <= {a_p2[31], a_p2} - {b_q30[31], b_q30};
  end

  // Angle of the (north, east) vector as whole degrees clockwise from north.
  gib_atan2 u_atan2 (
    .clk(clk), .rst(rst), .in_valid(p3_vld), .east(east_p3), .north(north_p3),
    .out_valid(done), .bearing(bearing_deg)
  );

`ifndef SYNTHESIS
  // Every accepted item produces its result after the fixed pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##TOTAL_LAT done)
    else $error("result strobe missing after pipeline latency");

  // A result strobe always stems from an item accepted earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(p3_vld, AT_LAT))
    else $error("result strobe without an item in the vectoring pipeline");

  // The bearing always lies within one turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (bearing_deg < FULL_TURN_DEG))
    else $error("bearing out of range");

  // The three rotation pipelines stay in step.
  a_sc_align: assert property (@(posedge clk) disable iff (rst)
    (sc_vld == sc2_vld) && (sc_vld == scd_vld))
    else $error("sine and cosine pipelines out of step");

  // All four coordinate dividers stay in step.
  a_div_align: assert property (@(posedge clk) disable iff (rst)
    (lat1_vld == lon1_vld) && (lat1_vld == lat2_vld) && (lat1_vld == lon2_vld))
    else $error("coordinate dividers out of step");
`endif

endmodule
